@@ src/trf_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// trf_pkg
// Shared constants and types for the threshold frame receiver.
// ---------------------------------------------------------------------------
package trf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LIMIT_W  = 7;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned FRAME_DIGITS = 4;

    localparam logic [BYTE_W-1:0] FRAME_OPEN  = 8'h3C;
    localparam logic [BYTE_W-1:0] FRAME_CLOSE = 8'h3E;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_NINE  = 8'h39;

    localparam logic [LIMIT_W-1:0] FLOOR_RESET   = 7'd50;
    localparam logic [LIMIT_W-1:0] CEILING_RESET = 7'd90;
    localparam logic [COUNT_W-1:0] DIGITS_FULL   = 3'(FRAME_DIGITS);

    typedef enum logic [0:0] {
        REG_FLOOR   = 1'b0,
        REG_CEILING = 1'b1
    } cfg_index_t;

    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [DIGIT_W-1:0] digit_t;

endpackage
`default_nettype wire

@@ src/threshold_frame_receiver_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// threshold_frame_receiver_core
// Parses '<dddd>' frames from a byte stream and emits range-checked limits.
// ---------------------------------------------------------------------------
// Path: a closing '>' passes the input register, then the result register,
// before its result leaves; output back-pressure can stall it between them.
// Throughput: one byte per cycle; a result held for out_ready stalls input.
// Reset: frame tracking and valid flags clear; floor resets to 50 and
// ceiling to 90. Digit storage is not cleared.
module threshold_frame_receiver_core
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output trf_pkg::limit_t             low_limit,
    output trf_pkg::limit_t             high_limit,
    input  wire logic                   cfg_we,
    input  wire trf_pkg::cfg_index_t    cfg_index,
    input  wire trf_pkg::limit_t        cfg_data
);
    import trf_pkg::*;

    limit_t              floor_reg;
    limit_t              ceiling_reg;
    logic                s1_valid_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic                in_frame_reg,  in_frame_next;
    logic [COUNT_W-1:0]  digits_seen_reg, digits_seen_next;
    digit_t              digit_store_reg [FRAME_DIGITS];
    logic                out_valid_reg, out_valid_next;
    limit_t              low_limit_reg;
    limit_t              high_limit_reg;

    logic                s1_fire;
    logic                is_digit;
    logic                store_we;
    digit_t              digit_val;
    logic                hit;
    limit_t              lo_val;
    limit_t              hi_val;
    limit_t              lo_clamped;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= FLOOR_RESET;
            ceiling_reg <= CEILING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLOOR:   floor_reg   <= cfg_data;
                REG_CEILING: ceiling_reg <= cfg_data;
                default:     floor_reg   <= floor_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // Frame decode
    assign is_digit  = (s1_byte_reg >= DIGIT_ZERO) && (s1_byte_reg <= DIGIT_NINE);
    assign digit_val = DIGIT_W'(s1_byte_reg - DIGIT_ZERO);
    assign lo_val    = LIMIT_W'(digit_store_reg[0]) * 7'd10 + LIMIT_W'(digit_store_reg[1]);
    assign hi_val    = LIMIT_W'(digit_store_reg[2]) * 7'd10 + LIMIT_W'(digit_store_reg[3]);
    assign lo_clamped = (lo_val > hi_val) ? hi_val : lo_val;

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        digits_seen_next = digits_seen_reg;
        store_we         = 1'b0;
        hit              = 1'b0;
        if (s1_byte_reg == FRAME_OPEN)
        begin
            in_frame_next    = 1'b1;
            digits_seen_next = '0;
        end
        else if (in_frame_reg)
        begin
            if (s1_byte_reg == FRAME_CLOSE)
            begin
                in_frame_next = 1'b0;
                hit = (digits_seen_reg == DIGITS_FULL)
                    && (lo_val >= floor_reg) && (lo_val <= ceiling_reg)
                    && (hi_val >= floor_reg) && (hi_val <= ceiling_reg);
            end
            else if (is_digit && (digits_seen_reg < DIGITS_FULL))
            begin
                store_we         = 1'b1;
                digits_seen_next = digits_seen_reg + 3'd1;
            end
            else
            begin
                in_frame_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            digits_seen_reg <= '0;
        end
        else if (s1_fire)
        begin
            in_frame_reg    <= in_frame_next;
            digits_seen_reg <= digits_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && store_we)
        begin
            digit_store_reg[digits_seen_reg[1:0]] <= digit_val;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = hit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && hit)
        begin
            low_limit_reg  <= lo_clamped;
            high_limit_reg <= hi_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign low_limit  = low_limit_reg;
    assign high_limit = high_limit_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digits_seen_reg <= DIGITS_FULL)
        else $error("digit count overflow");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (low_limit_reg <= high_limit_reg))
        else $error("low limit above high limit");

    a_open_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_byte_reg == FRAME_OPEN)) |=>
            (in_frame_reg && (digits_seen_reg == '0)))
        else $error("open byte did not restart frame");

    a_result_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_byte_reg != FRAME_CLOSE)) |=> !out_valid_reg)
        else $error("result without closing byte");

endmodule
`default_nettype wire
